@@ src/seven_segment_two_wire_display_sender_top_assert.svh @@
// Assertion macros shared by the display sender modules.
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_SENDER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_SENDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SSD_ASSERT_IMP(lbl, aclk, arst_n, ante, cons) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
    else $error("display sender check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SSD_ASSERT_NEXT(lbl, aclk, arst_n, ante, cons) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |=> (cons)) \
    else $error("display sender check failed");
`else
`define SSD_ASSERT_IMP(lbl, aclk, arst_n, ante, cons)
`define SSD_ASSERT_NEXT(lbl, aclk, arst_n, ante, cons)
`endif
`endif

@@ src/ssd_pkg.sv @@
// Types, codes and the segment table of the display sender.
`default_nettype none
package ssd_pkg;

  // Request codes carried by the action field
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_DIGITS = 2'd1;
  localparam logic [1:0] ACT_TIME   = 2'd2;

  // Controller command bytes
  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_DISP  = 8'h8F;
  localparam logic [7:0] COLON_BIT = 8'b1000_0000;

  typedef logic [3:0][7:0] seg_bank_t;

  // Commands from the word pipeline to the pin sequencer
  typedef struct packed {
    logic load;
    logic step;
  } seq_cmd_t;

  // Pin levels and flags after one word
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy;
    logic taken;
    logic ended;
  } seq_res_t;

  // Segment pattern of one digit code; codes 10, 14 and 15 are blank
  function automatic logic [7:0] seg_of(input logic [3:0] code);
    logic [7:0] pat;
    case (code)
      4'd0:    pat = 8'b0011_1111;
      4'd1:    pat = 8'b0000_0110;
      4'd2:    pat = 8'b0101_1011;
      4'd3:    pat = 8'b0100_1111;
      4'd4:    pat = 8'b0110_0110;
      4'd5:    pat = 8'b0110_1101;
      4'd6:    pat = 8'b0111_1101;
      4'd7:    pat = 8'b0000_0111;
      4'd8:    pat = 8'b0111_1111;
      4'd9:    pat = 8'b0110_1111;
      4'd11:   pat = 8'b0111_1001;
      4'd12:   pat = 8'b0101_1110;
      4'd13:   pat = 8'b0000_0110;
      default: pat = 8'b0000_0000;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

@@ src/ssd_req_map.sv @@
// Turns a show request into the four segment bytes.
`default_nettype none
module ssd_req_map (
  input  wire logic            time_mode,
  input  wire logic [3:0]      digit0,
  input  wire logic [3:0]      digit1,
  input  wire logic [3:0]      digit2,
  input  wire logic [3:0]      digit3,
  input  wire logic            colon_on,
  input  wire logic [7:0]      minutes,
  input  wire logic [7:0]      seconds,
  output ssd_pkg::seg_bank_t   bank
);
  import ssd_pkg::*;

  logic [6:0]  min_sat;
  logic [6:0]  sec_sat;
  logic [14:0] min_prod;
  logic [14:0] sec_prod;
  logic [3:0]  min_tens;
  logic [3:0]  sec_tens;
  logic [3:0]  min_units;
  logic [3:0]  sec_units;
  logic [3:0]  code [4];
  logic        colon;

  // Saturate at 99
  assign min_sat = (minutes > 8'd99) ? 7'd99 : minutes[6:0];
  assign sec_sat = (seconds > 8'd99) ? 7'd99 : seconds[6:0];

  // Split into tens and units: x/10 == (x*205)>>11 for x below 100
  assign min_prod  = 15'(min_sat) * 15'd205;
  assign sec_prod  = 15'(sec_sat) * 15'd205;
  assign min_tens  = min_prod[14:11];
  assign sec_tens  = sec_prod[14:11];
  assign min_units = 4'(min_sat - 7'(min_tens) * 7'd10);
  assign sec_units = 4'(sec_sat - 7'(sec_tens) * 7'd10);

  // Choose the codes and colon of the mode
  always_comb begin
    if (time_mode) begin
      code[0] = min_tens;
      code[1] = min_units;
      code[2] = sec_tens;
      code[3] = sec_units;
      colon   = 1'b1;
    end else begin
      code[0] = digit0;
      code[1] = digit1;
      code[2] = digit2;
      code[3] = digit3;
      colon   = colon_on;
    end
  end

  // Look up the patterns and add the colon to the second digit
  assign bank[0] = seg_of(code[0]);
  assign bank[1] = seg_of(code[1]) | (colon ? COLON_BIT : 8'h00);
  assign bank[2] = seg_of(code[2]);
  assign bank[3] = seg_of(code[3]);

endmodule
`default_nettype wire

@@ src/ssd_pin_seq.sv @@
// Pin sequencer: walks the three frames one pin write per step.
`default_nettype none
`include "seven_segment_two_wire_display_sender_top_assert.svh"
module ssd_pin_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ssd_pkg::seq_cmd_t  cmd,
  input  wire ssd_pkg::seg_bank_t bank,
  output logic               running,
  output ssd_pkg::seq_res_t  res
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_BITS, PH_ACK, PH_STOP} phase_t;

  localparam logic [1:0] FRAME_LAST = 2'd2;

  phase_t    phase_r, phase_nxt;
  logic [1:0] frame_r, frame_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [2:0] byte_r, byte_nxt;
  logic       running_r, running_nxt;
  logic       clk_pin_r, clk_pin_nxt;
  logic       dio_pin_r, dio_pin_nxt;
  seg_bank_t  seg_r, seg_nxt;
  logic [7:0] cur_byte;
  logic       last_byte;
  logic       ended;

  // Select the byte in flight
  always_comb begin
    case (byte_r)
      3'd0:    cur_byte = CMD_DATA;
      3'd1:    cur_byte = CMD_ADDR;
      3'd2:    cur_byte = seg_r[0];
      3'd3:    cur_byte = seg_r[1];
      3'd4:    cur_byte = seg_r[2];
      3'd5:    cur_byte = seg_r[3];
      default: cur_byte = CMD_DISP;
    endcase
  end

  // Last byte of its frame
  assign last_byte = (byte_r == 3'd0) || (byte_r == 3'd5) || (byte_r == 3'd6);

  // Advance the sequence by one pin write, or latch a new request
  always_comb begin
    phase_nxt   = phase_r;
    frame_nxt   = frame_r;
    cnt_nxt     = cnt_r;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    running_nxt = running_r;
    clk_pin_nxt = clk_pin_r;
    dio_pin_nxt = dio_pin_r;
    seg_nxt     = seg_r;
    ended       = 1'b0;
    if (cmd.load) begin
      seg_nxt     = bank;
      phase_nxt   = PH_START;
      frame_nxt   = 2'd0;
      cnt_nxt     = 2'd0;
      bit_nxt     = 3'd0;
      byte_nxt    = 3'd0;
      running_nxt = 1'b1;
    end else if (cmd.step) begin
      case (phase_r)
        PH_START: begin
          case (cnt_r)
            2'd0:    clk_pin_nxt = 1'b1;
            2'd1:    dio_pin_nxt = 1'b1;
            default: dio_pin_nxt = 1'b0;
          endcase
          if (cnt_r == 2'd2) begin
            cnt_nxt   = 2'd0;
            phase_nxt = PH_BITS;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        PH_BITS: begin
          case (cnt_r)
            2'd0:    clk_pin_nxt = 1'b0;
            2'd1:    dio_pin_nxt = cur_byte[bit_r];
            default: clk_pin_nxt = 1'b1;
          endcase
          if (cnt_r == 2'd2) begin
            cnt_nxt = 2'd0;
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              phase_nxt = PH_ACK;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        PH_ACK: begin
          if (cnt_r == 2'd0) begin
            clk_pin_nxt = 1'b0;
            cnt_nxt     = 2'd1;
          end else begin
            clk_pin_nxt = 1'b1;
            cnt_nxt     = 2'd0;
            byte_nxt    = byte_r + 3'd1;
            phase_nxt   = last_byte ? PH_STOP : PH_BITS;
          end
        end
        default: begin
          case (cnt_r)
            2'd0:    clk_pin_nxt = 1'b0;
            2'd1:    dio_pin_nxt = 1'b0;
            2'd2:    clk_pin_nxt = 1'b1;
            default: dio_pin_nxt = 1'b1;
          endcase
          if (cnt_r == 2'd3) begin
            cnt_nxt   = 2'd0;
            phase_nxt = PH_START;
            if (frame_r == FRAME_LAST) begin
              frame_nxt   = 2'd0;
              byte_nxt    = 3'd0;
              running_nxt = 1'b0;
              ended       = 1'b1;
            end else begin
              frame_nxt = frame_r + 2'd1;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      endcase
    end
  end

  // Hold sequencer state and pin levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      frame_r   <= 2'd0;
      cnt_r     <= 2'd0;
      bit_r     <= 3'd0;
      byte_r    <= 3'd0;
      running_r <= 1'b0;
      clk_pin_r <= 1'b1;
      dio_pin_r <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      frame_r   <= frame_nxt;
      cnt_r     <= cnt_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      running_r <= running_nxt;
      clk_pin_r <= clk_pin_nxt;
      dio_pin_r <= dio_pin_nxt;
    end
    seg_r <= seg_nxt;
  end

  assign running       = running_r;
  assign res.clk_level = clk_pin_nxt;
  assign res.dio_level = dio_pin_nxt;
  assign res.busy      = running_nxt;
  assign res.taken     = cmd.load;
  assign res.ended     = ended;

  // Idle always sits at the head of the first frame
  `SSD_ASSERT_IMP(a_idle_home, clk, rst_n, !running_r,
    (phase_r == PH_START) && (cnt_r == 2'd0) && (frame_r == 2'd0) && (byte_r == 3'd0))
  // A latched request starts the sequence
  `SSD_ASSERT_NEXT(a_load_runs, clk, rst_n, cmd.load, running_r)
  // The end only comes from the stop of the last frame
  `SSD_ASSERT_IMP(a_end_in_stop, clk, rst_n, ended,
    (phase_r == PH_STOP) && (frame_r == FRAME_LAST) && (cnt_r == 2'd3))

endmodule
`default_nettype wire

@@ src/seven_segment_two_wire_display_sender_top.sv @@
// Top level of the display sender: word register, request mapping, sequencer, result register.
// A word held in the word register goes through the sequencer into the result register once that register is free.
// One word per cycle while the result register is not stalled; the sequencer takes one pin step per tick word.
// A full display update is one show word plus 203 tick words, so the link runs at the tick rate.
// Reset: synchronous active low; the sequencer pin levels go high, the sequencer is idle and both stages are empty.
`default_nettype none
`include "seven_segment_two_wire_display_sender_top_assert.svh"
module seven_segment_two_wire_display_sender_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [3:0] in_digit0,
  input  wire logic [3:0] in_digit1,
  input  wire logic [3:0] in_digit2,
  input  wire logic [3:0] in_digit3,
  input  wire logic       in_colon_on,
  input  wire logic [7:0] in_minutes,
  input  wire logic [7:0] in_seconds,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_clk_level,
  output logic            out_dio_level,
  output logic            out_busy_res,
  output logic            out_request_taken,
  output logic            out_sequence_end
);
  import ssd_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [1:0] action_r;
  logic [3:0] digit0_r, digit1_r, digit2_r, digit3_r;
  logic       colon_r;
  logic [7:0] minutes_r, seconds_r;
  logic       out_valid_r, out_valid_nxt;
  seq_res_t   out_r;
  logic       advance;
  logic       fire;
  logic       in_take;
  logic       busy;
  logic       is_show;
  seq_cmd_t   cmd;
  seg_bank_t  bank;
  seq_res_t   res;

  // Handshake: the result register frees the word register
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  assign in_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Drop show words while running, step only while running
  assign is_show  = (action_r == ACT_DIGITS) || (action_r == ACT_TIME);
  assign cmd.load = fire && is_show && !busy;
  assign cmd.step = fire && (action_r == ACT_TICK) && busy;

  ssd_req_map u_map (
    .time_mode (action_r == ACT_TIME),
    .digit0    (digit0_r),
    .digit1    (digit1_r),
    .digit2    (digit2_r),
    .digit3    (digit3_r),
    .colon_on  (colon_r),
    .minutes   (minutes_r),
    .seconds   (seconds_r),
    .bank      (bank)
  );

  ssd_pin_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .bank    (bank),
    .running (busy),
    .res     (res)
  );

  // Hold the word and result stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_take) begin
      action_r  <= in_action;
      digit0_r  <= in_digit0;
      digit1_r  <= in_digit1;
      digit2_r  <= in_digit2;
      digit3_r  <= in_digit3;
      colon_r   <= in_colon_on;
      minutes_r <= in_minutes;
      seconds_r <= in_seconds;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clk_level     = out_r.clk_level;
  assign out_dio_level     = out_r.dio_level;
  assign out_busy_res      = out_r.busy;
  assign out_request_taken = out_r.taken;
  assign out_sequence_end  = out_r.ended;

  // Loading and stepping never share a word
  `SSD_ASSERT_IMP(a_cmd_excl, clk, rst_n, 1'b1, !(cmd.load && cmd.step))
  // A finished sequence reports idle
  `SSD_ASSERT_IMP(a_end_idle, clk, rst_n, out_valid_r && out_r.ended, !out_r.busy)
  // A taken request reports busy and no end
  `SSD_ASSERT_IMP(a_taken_busy, clk, rst_n, out_valid_r && out_r.taken,
    out_r.busy && !out_r.ended)

endmodule
`default_nettype wire
